>>> design/psm_pkg.sv
package psm_pkg;

    localparam int STACK_DEPTH = 512;
    localparam int CODE_DEPTH  = 1024;
    localparam int MAX_LEVEL   = 7;
    localparam int WORD_BITS   = 32;

    // instruction modes
    localparam logic [3:0] OP_LIT = 4'd0;
    localparam logic [3:0] OP_OPR = 4'd1;
    localparam logic [3:0] OP_LOD = 4'd2;
    localparam logic [3:0] OP_STO = 4'd3;
    localparam logic [3:0] OP_CAL = 4'd4;
    localparam logic [3:0] OP_INT = 4'd5;
    localparam logic [3:0] OP_JMP = 4'd6;
    localparam logic [3:0] OP_JPC = 4'd7;
    localparam logic [3:0] OP_RED = 4'd8;
    localparam logic [3:0] OP_WRT = 4'd9;

    // operator functions
    localparam logic [3:0] FN_RET = 4'd0;
    localparam logic [3:0] FN_NEG = 4'd1;
    localparam logic [3:0] FN_ADD = 4'd2;
    localparam logic [3:0] FN_SUB = 4'd3;
    localparam logic [3:0] FN_MUL = 4'd4;
    localparam logic [3:0] FN_DIV = 4'd5;
    localparam logic [3:0] FN_ODD = 4'd6;
    localparam logic [3:0] FN_MOD = 4'd7;
    localparam logic [3:0] FN_EQL = 4'd8;
    localparam logic [3:0] FN_NEQ = 4'd9;
    localparam logic [3:0] FN_LSS = 4'd10;
    localparam logic [3:0] FN_LEQ = 4'd11;
    localparam logic [3:0] FN_GTR = 4'd12;
    localparam logic [3:0] FN_GEQ = 4'd13;

    // fault codes
    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_ILL   = 2'd1;
    localparam logic [1:0] FLT_DIV0  = 2'd2;
    localparam logic [1:0] FLT_RANGE = 2'd3;

    // divider request and reply
    typedef struct packed {
        logic        start;
        logic        is_mod;
    } div_ctl_t;

    typedef struct packed {
        logic        busy;
        logic        done;
    } div_sts_t;

endpackage

>>> design/psm_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module psm_div #(
    parameter int WORD_BITS = psm_pkg::WORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  psm_pkg::div_ctl_t    ctl,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output psm_pkg::div_sts_t    sts,
    output logic [WORD_BITS-1:0] result
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] den_reg, den_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 negq_reg, negq_next;
    logic                 negr_reg, negr_next;
    logic                 mod_reg, mod_next;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        negq_next = negq_reg;
        negr_next = negr_reg;
        mod_next  = mod_reg;
        shifted   = {rem_reg, quo_reg[WORD_BITS-1]};
        trial     = shifted - {1'b0, den_reg};
        if (ctl.start) begin
            // load magnitudes
            quo_next  = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
            rem_next  = '0;
            cnt_next  = CW'(WORD_BITS);
            busy_next = 1'b1;
            negq_next = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
            negr_next = dividend[WORD_BITS-1];
            mod_next  = ctl.is_mod;
        end else if (busy_reg) begin
            if (!trial[WORD_BITS]) begin
                rem_next = trial[WORD_BITS-1:0];
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b1};
            end else begin
                rem_next = shifted[WORD_BITS-1:0];
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        mod_reg  <= mod_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = mod_reg ? (negr_reg ? (~rem_reg + 1'b1) : rem_reg)
                              : (negq_reg ? (~quo_reg + 1'b1) : quo_reg);

`ifndef SYNTHESIS
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (cnt_reg == '0 || $past(busy_reg)))
        else $error("divider count left over");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without work");
    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(done_reg && busy_reg))
        else $error("divider busy and done");
`endif
endmodule

>>> design/psm_stack_ram.sv
// Stack word memory, one port, registered read data.
module psm_stack_ram #(
    parameter int STACK_DEPTH = psm_pkg::STACK_DEPTH,
    parameter int WORD_BITS   = psm_pkg::WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [$clog2(STACK_DEPTH)-1:0] addr,
    input  logic [WORD_BITS-1:0]           wdata,
    output logic [WORD_BITS-1:0]           rdata
);
    logic [WORD_BITS-1:0] mem [STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> design/pcode_stack_machine_top.sv
// P-code stack machine: one instruction per s_axis transaction, one result per instruction.
// Steps: ST_WALK/ST_WALKW per static link, ST_RDA/ST_RDAW and ST_RDB/ST_RDBW per stack
// read, ST_EXEC, ST_DIVW for div and mod, ST_WR (four words for a call), ST_DONE.
// One instruction in flight; the next is taken in ST_IDLE once its result is registered
// and the output register is empty or draining. Once stopped, an accepted instruction
// goes straight to ST_DONE. Reset (aresetn low, synchronous): control registers reset
// (bp to 1), then a clearing pass zeroes the stack memory while s_axis_tready stays low.
module pcode_stack_machine_top #(
    parameter int STACK_DEPTH = psm_pkg::STACK_DEPTH,
    parameter int CODE_DEPTH  = psm_pkg::CODE_DEPTH,
    parameter int MAX_LEVEL   = psm_pkg::MAX_LEVEL,
    parameter int WORD_BITS   = psm_pkg::WORD_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [3:0] mode, [6:4] level, [38:7] operand, [70:39] read_value, zero fill
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [9:0] next_pc, [18:10] new_frame_base, [27:19] new_stack_top,
    // [28] print_valid, [60:29] print_value, [61] finished, [63:62] fault
    output logic [63:0]  m_axis_tdata
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(CODE_DEPTH);
    localparam int LW = $clog2(MAX_LEVEL + 1);
    localparam int XW = WORD_BITS + 2;   // signed index arithmetic width

    // sequencer states
    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_WALK  = 4'd2;
    localparam logic [3:0] ST_WALKW = 4'd3;
    localparam logic [3:0] ST_RDA   = 4'd4;
    localparam logic [3:0] ST_RDAW  = 4'd5;
    localparam logic [3:0] ST_RDB   = 4'd6;
    localparam logic [3:0] ST_RDBW  = 4'd7;
    localparam logic [3:0] ST_EXEC  = 4'd8;
    localparam logic [3:0] ST_DIVW  = 4'd9;
    localparam logic [3:0] ST_WR    = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0]           state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [AW-1:0]        sp_reg, sp_next;
    logic [AW-1:0]        bp_reg, bp_next;
    logic [PW-1:0]        pc_reg, pc_next;
    logic                 stop_reg, stop_next;
    logic [3:0]           mode_reg, mode_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic [WORD_BITS-1:0] opd_reg, opd_next;
    logic [WORD_BITS-1:0] rv_reg, rv_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [2:0]           wcnt_reg, wcnt_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    logic [AW-1:0]        nsp_reg, nsp_next;
    logic [AW-1:0]        nbp_reg, nbp_next;
    logic [PW-1:0]        npc_reg, npc_next;
    logic [1:0]           flt_reg, flt_next;
    logic                 ov_reg, ov_next;
    logic [63:0]          out_reg, out_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
    psm_pkg::div_ctl_t    dctl;
    psm_pkg::div_sts_t    dsts;
    logic [WORD_BITS-1:0] dres;

    logic [3:0]           in_mode;
    logic [2:0]           in_lvl;
    logic [31:0]          in_opd, in_rv;
    logic [3:0]           fn;
    logic                 fn_ok;
    logic [XW-1:0]        idx_a, idx_b, idx_st;
    logic                 rng_a, rng_b, rng_st;
    logic                 need_a, need_b, need_walk;
    logic [XW-1:0]        ext_opd, sp_x, bp_x, base_x, t_sp, t_bp;
    logic                 slt, blt;
    logic [WORD_BITS-1:0] alu;
    logic [WORD_BITS-1:0] mulp;

    psm_stack_ram #(.STACK_DEPTH(STACK_DEPTH), .WORD_BITS(WORD_BITS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    psm_div #(.WORD_BITS(WORD_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dctl),
        .dividend (a_reg),
        .divisor  (b_reg),
        .sts      (dsts),
        .result   (dres)
    );

    assign in_mode = s_axis_tdata[3:0];
    assign in_lvl  = s_axis_tdata[6:4];
    assign in_opd  = s_axis_tdata[38:7];
    assign in_rv   = s_axis_tdata[70:39];

    // index helpers on the latched instruction
    assign ext_opd = {{2{opd_reg[WORD_BITS-1]}}, opd_reg};
    assign sp_x    = XW'(sp_reg);
    assign bp_x    = XW'(bp_reg);
    assign base_x  = XW'(base_reg);
    assign fn      = opd_reg[3:0];
    assign fn_ok   = (opd_reg[WORD_BITS-1:4] == '0) && (fn <= psm_pkg::FN_GEQ);
    assign mulp    = a_reg * b_reg;
    assign slt     = $signed(a_reg) < $signed(b_reg);
    assign blt     = $signed(b_reg) < $signed(a_reg);

    // which words an instruction reads (a first, b second) and where
    always_comb begin
        idx_a  = sp_x;
        idx_b  = sp_x;
        need_a = 1'b0;
        need_b = 1'b0;
        need_walk = 1'b0;
        case (mode_reg)
            psm_pkg::OP_OPR: begin
                if (fn == psm_pkg::FN_RET) begin
                    idx_a = bp_x + XW'(3);
                    idx_b = bp_x + XW'(2);
                    need_a = 1'b1;
                    need_b = 1'b1;
                end else if (fn == psm_pkg::FN_NEG || fn == psm_pkg::FN_ODD) begin
                    need_a = 1'b1;
                end else begin
                    idx_a = sp_x - XW'(1);
                    need_a = 1'b1;
                    need_b = 1'b1;
                end
            end
            psm_pkg::OP_LOD: begin
                idx_a = base_x + ext_opd;
                need_a = 1'b1;
                need_walk = 1'b1;
            end
            psm_pkg::OP_STO: begin
                need_a = 1'b1;
                need_walk = 1'b1;
            end
            psm_pkg::OP_CAL: need_walk = 1'b1;
            psm_pkg::OP_JPC, psm_pkg::OP_WRT: need_a = 1'b1;
            default: ;
        endcase
    end

    assign rng_a = (idx_a[XW-1] == 1'b0) && (idx_a < XW'(STACK_DEPTH));
    assign rng_b = (idx_b[XW-1] == 1'b0) && (idx_b < XW'(STACK_DEPTH));
    assign idx_st = base_x + ext_opd;
    assign rng_st = (idx_st[XW-1] == 1'b0) && (idx_st < XW'(STACK_DEPTH));
    assign t_sp   = sp_x + ext_opd;
    assign t_bp   = bp_x - XW'(1);

    // operator result
    always_comb begin
        alu = '0;
        case (fn)
            psm_pkg::FN_NEG: alu = ~a_reg + 1'b1;
            psm_pkg::FN_ODD: alu = {{(WORD_BITS-1){1'b0}}, a_reg[0]};
            psm_pkg::FN_ADD: alu = a_reg + b_reg;
            psm_pkg::FN_SUB: alu = a_reg - b_reg;
            psm_pkg::FN_MUL: alu = mulp;
            psm_pkg::FN_EQL: alu = WORD_BITS'(a_reg == b_reg);
            psm_pkg::FN_NEQ: alu = WORD_BITS'(a_reg != b_reg);
            psm_pkg::FN_LSS: alu = WORD_BITS'(slt);
            psm_pkg::FN_LEQ: alu = WORD_BITS'(!blt);
            psm_pkg::FN_GTR: alu = WORD_BITS'(blt);
            psm_pkg::FN_GEQ: alu = WORD_BITS'(!slt);
            default: alu = dres;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        sp_next    = sp_reg;
        bp_next    = bp_reg;
        pc_next    = pc_reg;
        stop_next  = stop_reg;
        mode_next  = mode_reg;
        lvl_next   = lvl_reg;
        opd_next   = opd_reg;
        rv_next    = rv_reg;
        base_next  = base_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        wcnt_next  = wcnt_reg;
        res_next   = res_reg;
        nsp_next   = nsp_reg;
        nbp_next   = nbp_reg;
        npc_next   = npc_reg;
        flt_next   = flt_reg;
        ov_next    = ov_reg;
        out_next   = out_reg;
        ram_we     = 1'b0;
        ram_addr   = clr_reg;
        ram_wdata  = '0;
        dctl.start = 1'b0;
        dctl.is_mod = (fn == psm_pkg::FN_MOD);
        s_axis_tready = 1'b0;

        if (ov_reg && m_axis_tready) begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_CLR: begin
                ram_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(STACK_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = !ov_reg || m_axis_tready;
                if (s_axis_tvalid && s_axis_tready) begin
                    mode_next = in_mode;
                    lvl_next  = (32'(in_lvl) > 32'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : LW'(in_lvl);
                    opd_next  = WORD_BITS'($signed(in_opd));
                    rv_next   = WORD_BITS'($signed(in_rv));
                    base_next = bp_reg;
                    flt_next  = psm_pkg::FLT_NONE;
                    wcnt_next = '0;
                    npc_next  = PW'(pc_reg + 1'b1);
                    nsp_next  = sp_reg;
                    nbp_next  = bp_reg;
                    state_next = stop_reg ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                // walk one static link per visit: issue the link read here, take it in ST_WALKW
                if (need_walk && lvl_reg != '0) begin
                    if (base_reg == AW'(STACK_DEPTH - 1)) begin
                        flt_next = psm_pkg::FLT_RANGE;
                        state_next = ST_EXEC;
                    end else begin
                        ram_addr = base_reg + 1'b1;
                        state_next = ST_WALKW;
                    end
                end else begin
                    state_next = ST_RDA;
                end
            end
            ST_WALKW: begin
                if (ram_rdata[WORD_BITS-1] || ram_rdata >= WORD_BITS'(STACK_DEPTH)) begin
                    flt_next = psm_pkg::FLT_RANGE;
                    state_next = ST_EXEC;
                end else begin
                    base_next = AW'(ram_rdata);
                    lvl_next  = lvl_reg - 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_RDA: begin
                if (need_a) begin
                    if (!rng_a) begin
                        flt_next = psm_pkg::FLT_RANGE;
                        state_next = ST_EXEC;
                    end else begin
                        ram_addr = AW'(idx_a);
                        state_next = ST_RDAW;
                    end
                end else begin
                    state_next = ST_RDB;
                end
            end
            ST_RDAW: begin
                a_next = ram_rdata;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                if (need_b) begin
                    if (!rng_b) begin
                        flt_next = psm_pkg::FLT_RANGE;
                        state_next = ST_EXEC;
                    end else begin
                        ram_addr = AW'(idx_b);
                        state_next = ST_RDBW;
                    end
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_RDBW: begin
                b_next = ram_rdata;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // decode effects; illegal beats range, range beats divide by zero
                state_next = ST_WR;
                case (mode_reg)
                    psm_pkg::OP_LIT: begin
                        nsp_next = sp_reg + 1'b1;
                        res_next = opd_reg;
                        if (sp_reg == AW'(STACK_DEPTH - 1)) flt_next = psm_pkg::FLT_RANGE;
                    end
                    psm_pkg::OP_OPR: begin
                        if (!fn_ok) begin
                            flt_next = psm_pkg::FLT_ILL;
                        end else if (flt_reg == psm_pkg::FLT_NONE) begin
                            if (fn == psm_pkg::FN_RET) begin
                                nsp_next = AW'(t_bp);
                                npc_next = PW'(a_reg);
                                nbp_next = AW'(b_reg);
                                if (b_reg[WORD_BITS-1] || b_reg >= WORD_BITS'(STACK_DEPTH)
                                    || t_bp[XW-1]) begin
                                    flt_next = psm_pkg::FLT_RANGE;
                                end
                            end else if (fn == psm_pkg::FN_NEG || fn == psm_pkg::FN_ODD) begin
                                res_next = alu;
                            end else begin
                                nsp_next = sp_reg - 1'b1;
                                if (fn == psm_pkg::FN_DIV || fn == psm_pkg::FN_MOD) begin
                                    if (b_reg == '0) begin
                                        flt_next = psm_pkg::FLT_DIV0;
                                    end else begin
                                        dctl.start = 1'b1;
                                        state_next = ST_DIVW;
                                    end
                                end else begin
                                    res_next = alu;
                                end
                            end
                        end
                    end
                    psm_pkg::OP_LOD: begin
                        nsp_next = sp_reg + 1'b1;
                        res_next = a_reg;
                        if (sp_reg == AW'(STACK_DEPTH - 1)) flt_next = psm_pkg::FLT_RANGE;
                    end
                    psm_pkg::OP_STO: begin
                        nsp_next = sp_reg - 1'b1;
                        res_next = a_reg;
                        if (!rng_st || sp_reg == '0) flt_next = psm_pkg::FLT_RANGE;
                    end
                    psm_pkg::OP_CAL: begin
                        nbp_next = sp_reg + 1'b1;
                        npc_next = PW'(opd_reg);
                        if (sp_x + XW'(4) >= XW'(STACK_DEPTH)) flt_next = psm_pkg::FLT_RANGE;
                    end
                    psm_pkg::OP_INT: begin
                        nsp_next = AW'(t_sp);
                        if (t_sp[XW-1] || t_sp >= XW'(STACK_DEPTH))
                            flt_next = psm_pkg::FLT_RANGE;
                    end
                    psm_pkg::OP_JMP: npc_next = PW'(opd_reg);
                    psm_pkg::OP_JPC: begin
                        nsp_next = sp_reg - 1'b1;
                        if (a_reg == '0) npc_next = PW'(opd_reg);
                        if (sp_reg == '0) flt_next = psm_pkg::FLT_RANGE;
                    end
                    psm_pkg::OP_RED: begin
                        nsp_next = sp_reg + 1'b1;
                        res_next = rv_reg;
                        if (sp_reg == AW'(STACK_DEPTH - 1)) flt_next = psm_pkg::FLT_RANGE;
                    end
                    psm_pkg::OP_WRT: begin
                        nsp_next = sp_reg - 1'b1;
                        res_next = a_reg;
                        if (sp_reg == '0) flt_next = psm_pkg::FLT_RANGE;
                    end
                    default: flt_next = psm_pkg::FLT_ILL;
                endcase
            end
            ST_DIVW: begin
                if (dsts.done) begin
                    res_next = dres;
                    state_next = ST_WR;
                end
            end
            ST_WR: begin
                // write back, one word per cycle; call writes four
                state_next = ST_DONE;
                if (flt_reg == psm_pkg::FLT_NONE) begin
                    case (mode_reg)
                        psm_pkg::OP_LIT, psm_pkg::OP_LOD, psm_pkg::OP_RED: begin
                            ram_we = 1'b1;
                            ram_addr = nsp_reg;
                            ram_wdata = res_reg;
                        end
                        psm_pkg::OP_OPR: begin
                            if (fn != psm_pkg::FN_RET) begin
                                ram_we = 1'b1;
                                ram_addr = nsp_reg;
                                ram_wdata = res_reg;
                            end
                        end
                        psm_pkg::OP_STO: begin
                            ram_we = 1'b1;
                            ram_addr = AW'(idx_st);
                            ram_wdata = res_reg;
                        end
                        psm_pkg::OP_CAL: begin
                            ram_we = 1'b1;
                            ram_addr = sp_reg + AW'(wcnt_reg) + 1'b1;
                            case (wcnt_reg)
                                3'd0: ram_wdata = '0;
                                3'd1: ram_wdata = WORD_BITS'(base_reg);
                                3'd2: ram_wdata = WORD_BITS'(bp_reg);
                                default: ram_wdata = WORD_BITS'(PW'(pc_reg + 1'b1));
                            endcase
                            wcnt_next = wcnt_reg + 1'b1;
                            if (wcnt_reg != 3'd3) state_next = ST_WR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DONE: begin
                if (!ov_reg || m_axis_tready) begin
                    ov_next = 1'b1;
                    if (stop_reg) begin
                        out_next = {psm_pkg::FLT_NONE, 1'b1, 32'd0, 1'b0,
                                    9'(sp_reg), 9'(bp_reg), 10'(pc_reg)};
                    end else if (flt_reg != psm_pkg::FLT_NONE) begin
                        out_next = {flt_reg, 1'b0, 32'd0, 1'b0,
                                    9'(sp_reg), 9'(bp_reg), 10'(pc_reg)};
                    end else begin
                        sp_next = nsp_reg;
                        bp_next = nbp_reg;
                        pc_next = npc_reg;
                        stop_next = (nbp_reg == '0);
                        out_next = {psm_pkg::FLT_NONE, nbp_reg == '0,
                                    (mode_reg == psm_pkg::OP_WRT) ? 32'(res_reg) : 32'd0,
                                    mode_reg == psm_pkg::OP_WRT,
                                    9'(nsp_reg), 9'(nbp_reg), 10'(npc_reg)};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            bp_reg    <= AW'(1);
            pc_reg    <= '0;
            stop_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            flt_reg   <= psm_pkg::FLT_NONE;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            bp_reg    <= bp_next;
            pc_reg    <= pc_next;
            stop_reg  <= stop_next;
            ov_reg    <= ov_next;
            flt_reg   <= flt_next;
        end
        mode_reg  <= mode_next;
        lvl_reg   <= lvl_next;
        opd_reg   <= opd_next;
        rv_reg    <= rv_next;
        base_reg  <= base_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        wcnt_reg  <= wcnt_next;
        res_reg   <= res_next;
        nsp_reg   <= nsp_next;
        nbp_reg   <= nbp_next;
        npc_reg   <= npc_next;
        out_reg   <= out_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_axis_tready)
        else $error("input taken during clearing pass");
    a_stop_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(stop_reg) |-> stop_reg)
        else $error("stopped flag cleared");
    a_fault_keeps_regs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && flt_reg != psm_pkg::FLT_NONE) |=> $stable(pc_reg))
        else $error("faulting instruction moved pc");
`endif
endmodule
